// ===== sv/psc_pkg.sv =====
package psc_pkg;

	// Scan constants
	localparam int unsigned RUN_NEEDED  = 15;
	localparam int unsigned BYTE_BITS   = 8;
	localparam logic [7:0]  ZERO_MASK   = 8'hf0;
	localparam int unsigned QUEUE_DEPTH = 2;

	// Rewind codes
	localparam logic [1:0] REWIND_NONE = 2'd0;
	localparam logic [1:0] REWIND_SAME = 2'd2;
	localparam logic [1:0] REWIND_NEXT = 2'd3;

	// One classified byte, passed from the front to the back
	typedef struct packed {
		logic [7:0] data;
		logic       is_zero;
		logic [2:0] lz;
		logic [3:0] tz;
	} cls_t;

	// Handshake pair between two parts
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

	// Leading zeros of a nonzero byte (0 to 7)
	function automatic logic [2:0] lead_zeros(input logic [7:0] b);
		logic [2:0] n;
		logic       hit;
		n   = '0;
		hit = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!hit && b[i]) begin
				n   = 3'(7 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	// Trailing zeros, 8 for a zero byte
	function automatic logic [3:0] trail_zeros(input logic [7:0] b);
		logic [3:0] n;
		logic       hit;
		n   = 4'(BYTE_BITS);
		hit = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!hit && b[i]) begin
				n   = 4'(i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

// ===== sv/psc_byte_if.sv =====
interface psc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== sv/psc_result_if.sv =====
interface psc_result_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [1:0] rewind;

	modport source (output valid, output found, output rewind, input ready);
	modport sink (input valid, input found, input rewind, output ready);
endinterface

// ===== sv/psc_front.sv =====
module psc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_data,
	output psc_pkg::hs_t   push_hs,
	input  logic           push_ready,
	output psc_pkg::cls_t  push_cls
);
	import psc_pkg::*;

	logic valid_s1;
	cls_t cls_s1;
	logic take;

	// Stage register empties when the queue takes it
	assign in_ready = !valid_s1 || push_ready;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Classify the byte on the way in
	always_ff @(posedge clk) begin
		if (take) begin
			cls_s1.data    <= in_data;
			cls_s1.is_zero <= (in_data == 8'h00);
			cls_s1.lz      <= lead_zeros(in_data);
			cls_s1.tz      <= trail_zeros(in_data);
		end
	end

	assign push_hs.valid = valid_s1;
	assign push_hs.ready = push_ready;
	assign push_cls      = cls_s1;
endmodule

// ===== sv/psc_queue.sv =====
module psc_queue #(
	parameter int unsigned DEPTH = psc_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  psc_pkg::cls_t  push_cls,
	output logic           pop_valid,
	input  logic           pop_ready,
	output psc_pkg::cls_t  pop_cls
);
	import psc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	cls_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cls    = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cls;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== sv/psc_back.sv =====
module psc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  psc_pkg::cls_t  pop_cls,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           out_found,
	output logic [1:0]     out_rewind
);
	import psc_pkg::*;

	logic [3:0] zero_run_q;
	logic       armed_q;
	logic       pending_q;
	logic [7:0] pending_bits_q;
	logic [2:0] one_pos_q;
	logic       valid_q;
	logic       found_q;
	logic [1:0] rewind_q;

	logic [3:0] zero_run_d;
	logic       armed_d;
	logic       pending_d;
	logic [7:0] pending_bits_d;
	logic [2:0] one_pos_d;
	logic       found_d;
	logic [1:0] rewind_d;

	logic [2:0] sh;
	logic [7:0] chk_bits;
	logic [4:0] run_sum;
	logic [4:0] grow;
	logic [7:0] after_one;
	logic       step;

	// Output register frees up when taken
	assign pop_ready = !valid_q || out_ready;
	assign step      = pop_valid && pop_ready;

	// Scan update for one byte
	always_comb begin
		sh         = 3'd7 - one_pos_q;
		chk_bits   = pending_bits_q | (pop_cls.data >> sh);
		run_sum    = {1'b0, zero_run_q} + {2'b00, pop_cls.lz};
		grow       = {1'b0, zero_run_q} + 5'(BYTE_BITS);
		after_one  = (pop_cls.data << pop_cls.lz) << 1;

		zero_run_d     = zero_run_q;
		armed_d        = armed_q;
		pending_d      = pending_q;
		pending_bits_d = pending_bits_q;
		one_pos_d      = one_pos_q;
		found_d        = 1'b0;
		rewind_d       = REWIND_NONE;

		if (pending_q) begin
			// second half of a low-nibble candidate
			pending_d = 1'b0;
			if ((chk_bits & ZERO_MASK) == 8'h00 && armed_q) begin
				found_d  = 1'b1;
				rewind_d = REWIND_NEXT;
			end
			zero_run_d = pop_cls.tz;
			armed_d    = 1'b1;
		end else if (pop_cls.is_zero) begin
			zero_run_d = (grow > 5'(RUN_NEEDED)) ? 4'(RUN_NEEDED) : grow[3:0];
		end else if (run_sum >= 5'(RUN_NEEDED)) begin
			if (pop_cls.lz > 3'd3) begin
				pending_d      = 1'b1;
				pending_bits_d = after_one;
				one_pos_d      = pop_cls.lz;
			end else begin
				if ((after_one & ZERO_MASK) == 8'h00 && armed_q) begin
					found_d  = 1'b1;
					rewind_d = REWIND_SAME;
				end
				zero_run_d = pop_cls.tz;
				armed_d    = 1'b1;
			end
		end else begin
			zero_run_d = pop_cls.tz;
			armed_d    = 1'b1;
		end
	end

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q     <= '0;
			armed_q        <= 1'b0;
			pending_q      <= 1'b0;
			pending_bits_q <= '0;
			one_pos_q      <= '0;
		end else if (step) begin
			zero_run_q     <= zero_run_d;
			armed_q        <= armed_d;
			pending_q      <= pending_d;
			pending_bits_q <= pending_bits_d;
			one_pos_q      <= one_pos_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			found_q  <= found_d;
			rewind_q <= rewind_d;
		end
	end

	assign out_valid  = valid_q;
	assign out_found  = found_q;
	assign out_rewind = rewind_q;
endmodule

// ===== sv/h261_psc_byte_scanner.sv =====
// Channel   Dir   Payload               Handshake
// stream    in    data_byte[7:0]        valid / ready
// result    out   found, rewind[1:0]    valid / ready
//
// One byte per cycle sustained while results are taken; a byte's result passes through
// the classify register, a queue slot, then the scan update into the result register.
// The per-byte scan state update in the back part sets the rate: one update a cycle while the result register is free.
// arst_n clears the scan state, the queue and all valid flags at once.
// A stalled result holds the back part; the queue then lets the front
// part take bytes until it fills.
module h261_psc_byte_scanner #(
	parameter int unsigned QUEUE_DEPTH = psc_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	psc_byte_if.sink      stream,
	psc_result_if.source  result
);
	import psc_pkg::*;

	hs_t  push_hs;
	cls_t push_cls;
	logic push_ready;
	logic pop_valid;
	logic pop_ready;
	cls_t pop_cls;

	// Front: accept and classify
	psc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (stream.valid),
		.in_ready   (stream.ready),
		.in_data    (stream.data_byte),
		.push_hs    (push_hs),
		.push_ready (push_ready),
		.push_cls   (push_cls)
	);

	// Queue between the two parts
	psc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_hs.valid),
		.push_ready (push_ready),
		.push_cls   (push_cls),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cls    (pop_cls)
	);

	// Back: scan state and result
	psc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cls    (pop_cls),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_found  (result.found),
		.out_rewind (result.rewind)
	);

	// A found result carries a rewind of two or three bytes
	a_found_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.found) |->
		(result.rewind == REWIND_SAME || result.rewind == REWIND_NEXT))
		else $error("found without a valid rewind");

	// No rewind without found
	a_rewind_none: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.found) |-> (result.rewind == REWIND_NONE))
		else $error("rewind set without found");

	// A classified byte blocked by a full queue stays in the front stage
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push_hs.valid && !push_hs.ready) |=> push_hs.valid)
		else $error("front stage dropped a request");
endmodule

// ===== verif/h261_psc_byte_scanner_tb.sv =====
`timescale 1ns / 100ps

module h261_psc_byte_scanner_tb;

	import psc_pkg::*;

	localparam int          RANDOM_BYTES = 1600;
	localparam int          CALM_TAIL    = 200;
	localparam int          N_DIRECTED   = 25;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	// One result: found flag and rewind code
	typedef struct packed {
		logic       found;
		logic [1:0] rewind;
	} scan_out_t;

	// One stimulus row; want is used only where fixed is set
	typedef struct packed {
		logic [7:0] data;
		logic       fixed;
		scan_out_t  want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	psc_byte_if   in_if ();
	psc_result_if out_if ();

	h261_psc_byte_scanner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (in_if),
		.result (out_if)
	);

	// Predictor state, zero from its declaration; the reset does not touch it
	logic [3:0] run_len    = '0;
	logic       armed_q    = 1'b0;
	logic       cand_wait  = 1'b0;
	logic [7:0] cand_bits  = '0;
	logic [2:0] cand_pos   = '0;

	scan_out_t   expected_q [$];
	stim_row_t   stim_q [$];
	int          mismatches   = 0;
	int          results_seen = 0;
	bit          calm_phase   = 1'b0;
	int unsigned cycle_count  = 0;

	// Directed rows: reset skip, both match kinds, failed checks, short run
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{8'h00, 1'b1, '{1'b0, REWIND_NONE}},
		'{8'h00, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h01, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h00, 1'b1, '{1'b0, REWIND_NONE}}, // start code at stream start: skipped
		'{8'h00, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h01, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h0f, 1'b1, '{1'b1, REWIND_NEXT}}, // low-nibble one, next byte pulled
		'{8'h00, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h00, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h80, 1'b1, '{1'b1, REWIND_SAME}}, // one at the top bit
		'{8'h00, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h10, 1'b1, '{1'b1, REWIND_SAME}}, // last high-nibble position
		'{8'h00, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h08, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'hff, 1'b0, '{1'b0, REWIND_NONE}}, // pulled byte fails the check
		'{8'h00, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h00, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'hc0, 1'b0, '{1'b0, REWIND_NONE}}, // same-byte check fails
		'{8'hff, 1'b0, '{1'b0, REWIND_NONE}}, // short run restart
		'{8'h00, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h00, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h04, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h80, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h00, 1'b0, '{1'b0, REWIND_NONE}},
		'{8'h02, 1'b0, '{1'b0, REWIND_NONE}}
	};

	function automatic logic [3:0] trailing_zero_count(input logic [7:0] b);
		int n;
		n = 0;
		while (n < 8 && !b[n])
			n++;
		return 4'(n);
	endfunction

	// Advance the scan state by one byte and return its result
	function automatic scan_out_t scan_byte(input logic [7:0] b);
		scan_out_t  r;
		logic [7:0] window;
		int         lz;
		r.found  = 1'b0;
		r.rewind = REWIND_NONE;
		if (cand_wait) begin
			// next byte completes the four check bits, whatever it holds
			window    = cand_bits | (b >> (7 - cand_pos));
			cand_wait = 1'b0;
			if ((window & ZERO_MASK) == 8'h00 && armed_q) begin
				r.found  = 1'b1;
				r.rewind = REWIND_NEXT;
			end
			run_len = trailing_zero_count(b);
			armed_q = 1'b1;
		end else if (b == 8'h00) begin
			run_len = (int'(run_len) + BYTE_BITS > RUN_NEEDED) ?
				4'(RUN_NEEDED) : 4'(int'(run_len) + BYTE_BITS);
		end else begin
			lz = 0;
			while (!b[7 - lz])
				lz++;
			if (int'(run_len) + lz >= RUN_NEEDED) begin
				window = b << (lz + 1);
				if (lz > 3) begin
					cand_wait = 1'b1;
					cand_bits = window;
					cand_pos  = 3'(lz);
				end else begin
					if ((window & ZERO_MASK) == 8'h00 && armed_q) begin
						r.found  = 1'b1;
						r.rewind = REWIND_SAME;
					end
					run_len = trailing_zero_count(b);
					armed_q = 1'b1;
				end
			end else begin
				run_len = trailing_zero_count(b);
				armed_q = 1'b1;
			end
		end
		return r;
	endfunction

	// Random part: a bit stream of start codes at any alignment, broken codes and noise
	task automatic build_random_stream(input int n_bytes);
		bit        stream_bits [$];
		int        kind;
		logic [3:0] nib;
		stim_row_t row;
		while (stim_q.size() < N_DIRECTED + n_bytes) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				repeat ($urandom_range(15, 26)) stream_bits.push_back(1'b0);
				stream_bits.push_back(1'b1);
				repeat (4) stream_bits.push_back(1'b0);
				repeat ($urandom_range(0, 24)) stream_bits.push_back(1'($urandom_range(0, 1)));
			end else if (kind < 8) begin
				// short zero run, or a full run with a one among the check bits
				repeat ($urandom_range(8, 16)) stream_bits.push_back(1'b0);
				stream_bits.push_back(1'b1);
				nib = 4'($urandom_range(1, 15));
				for (int k = 3; k >= 0; k--)
					stream_bits.push_back(nib[k]);
			end else begin
				repeat ($urandom_range(1, 40)) stream_bits.push_back(1'($urandom_range(0, 1)));
			end
			while (stream_bits.size() >= 8) begin
				row = '0;
				for (int k = 7; k >= 0; k--)
					row.data[k] = stream_bits.pop_front();
				stim_q.push_back(row);
			end
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Reset, once
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	// Request sender with random idle bursts; the end is checked here too
	initial begin
		int idle_odds;
		scan_out_t predicted;
		in_if.valid     = 1'b0;
		in_if.data_byte = '0;
		idle_odds       = 0;
		foreach (directed_rows[i])
			stim_q.push_back(directed_rows[i]);
		build_random_stream(RANDOM_BYTES);
		@(posedge arst_n);
		@(negedge clk);
		for (int i = 0; i < stim_q.size(); i++) begin
			if (i % 100 == 0)
				idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
			if (i >= stim_q.size() - CALM_TAIL)
				calm_phase = 1'b1;
			if (!calm_phase && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				in_if.valid <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			in_if.valid     <= 1'b1;
			in_if.data_byte <= stim_q[i].data;
			do
				@(posedge clk);
			while (!in_if.ready);
			predicted = scan_byte(stim_q[i].data);
			expected_q.push_back(stim_q[i].fixed ? stim_q[i].want : predicted);
			@(negedge clk);
		end
		in_if.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Result receiver: random stall bursts and one long hold-off to back up the block
	initial begin
		int  stall_odds;
		int  since_mode;
		bit  long_done;
		out_if.ready = 1'b0;
		stall_odds   = 0;
		since_mode   = 0;
		long_done    = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (since_mode == 0) begin
				stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(4, 20);
				since_mode = 150;
			end
			since_mode--;
			if (!long_done && results_seen >= 400) begin
				out_if.ready <= 1'b0;
				repeat (300) @(negedge clk);
				long_done = 1'b1;
			end else if (!calm_phase && stall_odds != 0 &&
					$urandom_range(1, stall_odds) == 1) begin
				out_if.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_if.ready <= 1'b1;
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		scan_out_t oldest;
		if (arst_n && out_if.valid && out_if.ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("result with none expected: found=%0d rewind=%0d",
					out_if.found, out_if.rewind);
				mismatches++;
			end else begin
				oldest = expected_q.pop_front();
				if (out_if.found !== oldest.found) begin
					$error("found: expected %0d, actual %0d", oldest.found, out_if.found);
					mismatches++;
				end
				if (out_if.rewind !== oldest.rewind) begin
					$error("rewind: expected %0d, actual %0d", oldest.rewind, out_if.rewind);
					mismatches++;
				end
			end
		end
	end

endmodule

// ===== h261_psc_byte_scanner.f =====
sv/psc_pkg.sv
sv/psc_byte_if.sv
sv/psc_result_if.sv
sv/psc_front.sv
sv/psc_queue.sv
sv/psc_back.sv
sv/h261_psc_byte_scanner.sv
verif/h261_psc_byte_scanner_tb.sv
